>>> rtl/core/dssa_pkg.sv
`timescale 1ns / 1ps
package dssa_pkg;

   localparam int STORE_DEPTH_DEFAULT = 32;
   localparam logic [7:0] FILL_BYTE = 8'h5F;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] CMD_PUSH = 2'd0;
   localparam logic [1:0] CMD_POP = 2'd1;
   localparam logic [1:0] CMD_PEEK = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_OVER = 2'd1;
   localparam logic [1:0] ST_UNDER = 2'd2;

   localparam logic MODE_INTERLEAVED = 1'b0;
   localparam logic MODE_COLLIDING = 1'b1;

   localparam logic [1:0] JOB_REPLY = 2'd0;
   localparam logic [1:0] JOB_WRITE = 2'd1;
   localparam logic [1:0] JOB_READ = 2'd2;
   localparam logic [1:0] JOB_READ_CLEAR = 2'd3;

   typedef struct packed {
      logic [1:0] command;
      logic       stack_select;
      logic [7:0] push_byte;
      logic [4:0] peek_slot;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] slot_touched;
      logic [7:0] data_byte;
   } rsp_type;

   typedef struct packed {
      logic [1:0] kind;
      rsp_type    rsp;
   } job_type;

endpackage

>>> rtl/core/dssa_ram.sv
`timescale 1ns / 1ps
module dssa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

>>> rtl/core/dssa_fifo.sv
`timescale 1ns / 1ps
module dssa_fifo
   import dssa_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full
);

   logic [WIDTH-1:0]    mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in = count_ff + (QUEUE_AW + 1)'(push) - (QUEUE_AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/core/dssa_front.sv
`timescale 1ns / 1ps
module dssa_front
   import dssa_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT,
   localparam int AW = $clog2(STORE_DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  req_type       req_word,
   input  logic          mode_write,
   input  logic          mode_word,
   output logic          enq,
   output job_type       job,
   output logic [AW-1:0] job_addr
);

   localparam int TW = AW + 2;
   localparam logic signed [TW-1:0] ZERO = '0;
   localparam logic signed [TW-1:0] ONE = TW'(1);
   localparam logic signed [TW-1:0] TWO = TW'(2);
   localparam logic signed [TW-1:0] DEPTH_S = TW'(STORE_DEPTH);
   localparam logic signed [TW-1:0] LAST_S = TW'(STORE_DEPTH - 1);

   logic                 mode_ff, mode_in;
   logic signed [TW-1:0] top_one_ff, top_one_in;
   logic signed [TW-1:0] top_two_ff, top_two_in;
   logic signed [TW-1:0] mine, slot, next_top;
   logic [31:0]          slot_w, peek_w;
   logic                 sel, colliding, slot_bad, update;

   assign enq = accept;

   always_comb begin
      sel = req_word.stack_select;
      colliding = (mode_ff == MODE_COLLIDING);
      mine = sel ? top_two_ff : top_one_ff;
      slot = mine;
      next_top = mine;
      update = 1'b0;
      peek_w = 32'(req_word.peek_slot);
      job.kind = JOB_REPLY;
      job.rsp.status = ST_OK;
      job.rsp.slot_touched = '0;
      job.rsp.data_byte = '0;
      job_addr = slot[AW-1:0];

      case (req_word.command)
         CMD_PUSH: begin
            slot = mine;
            if (colliding) begin
               next_top = sel ? mine - ONE : mine + ONE;
            end else begin
               next_top = mine + TWO;
            end
         end
         CMD_POP: begin
            if (colliding) begin
               slot = sel ? mine + ONE : mine - ONE;
            end else begin
               slot = mine - TWO;
            end
            next_top = slot;
         end
         default: begin
            slot = mine;
         end
      endcase

      slot_w = 32'(slot);
      slot_bad = (slot < ZERO) || (slot >= DEPTH_S);
      job_addr = slot[AW-1:0];

      case (req_word.command)
         CMD_PUSH: begin
            if (slot_bad || (colliding && (top_one_ff > top_two_ff))) begin
               job.rsp.status = ST_OVER;
            end else begin
               job.kind = JOB_WRITE;
               job.rsp.slot_touched = slot_w[4:0];
               job.rsp.data_byte = req_word.push_byte;
               update = 1'b1;
            end
         end
         CMD_POP: begin
            if (slot_bad || (!colliding && sel && (slot < ONE))) begin
               job.rsp.status = ST_UNDER;
            end else begin
               job.kind = JOB_READ_CLEAR;
               job.rsp.slot_touched = slot_w[4:0];
               update = 1'b1;
            end
         end
         CMD_PEEK: begin
            job.rsp.slot_touched = req_word.peek_slot;
            job_addr = peek_w[AW-1:0];
            if (peek_w < 32'(STORE_DEPTH)) begin
               job.kind = JOB_READ;
            end else begin
               job.rsp.data_byte = FILL_BYTE;
            end
         end
         default: begin
            job.kind = JOB_REPLY;
         end
      endcase

      mode_in = mode_ff;
      top_one_in = top_one_ff;
      top_two_in = top_two_ff;
      if (accept && update) begin
         if (sel) begin
            top_two_in = next_top;
         end else begin
            top_one_in = next_top;
         end
      end
      if (mode_write) begin
         mode_in = mode_word;
         top_one_in = ZERO;
         top_two_in = (mode_word == MODE_COLLIDING) ? LAST_S : ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_INTERLEAVED;
         top_one_ff <= ZERO;
         top_two_ff <= ONE;
      end else begin
         mode_ff <= mode_in;
         top_one_ff <= top_one_in;
         top_two_ff <= top_two_in;
      end
   end

endmodule

>>> rtl/core/dssa_back.sv
`timescale 1ns / 1ps
module dssa_back
   import dssa_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT,
   localparam int AW = $clog2(STORE_DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          clear_start,
   input  logic          q_empty,
   input  job_type       q_job,
   input  logic [AW-1:0] q_addr,
   output logic          q_pop,
   output logic          clearing,
   output logic          rsp_strobe,
   output rsp_type       rsp_word
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_WAIT = 1'b1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);

   logic          state_ff, state_in;
   logic          clr_ff, clr_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   job_type       job_ff, job_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;

   dssa_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_ram (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (ram_waddr),
      .wr_data    (ram_wdata),
      .rd_en      (ram_re),
      .rd_addr    (ram_raddr),
      .rd_data_ff (ram_rdata)
   );

   assign clearing = clr_ff;
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word = rsp_ff;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      clr_addr_in = clr_addr_ff;
      job_in = job_ff;
      addr_in = addr_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      q_pop = 1'b0;
      ram_we = 1'b0;
      ram_waddr = clr_addr_ff;
      ram_wdata = FILL_BYTE;
      ram_re = 1'b0;
      ram_raddr = q_addr;

      if (clr_ff) begin
         ram_we = 1'b1;
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clr_in = 1'b0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  q_pop = 1'b1;
                  job_in = q_job;
                  addr_in = q_addr;
                  case (q_job.kind)
                     JOB_WRITE: begin
                        ram_we = 1'b1;
                        ram_waddr = q_addr;
                        ram_wdata = q_job.rsp.data_byte;
                        rsp_valid_in = 1'b1;
                        rsp_in = q_job.rsp;
                     end
                     JOB_READ, JOB_READ_CLEAR: begin
                        ram_re = 1'b1;
                        state_in = S_WAIT;
                     end
                     default: begin
                        rsp_valid_in = 1'b1;
                        rsp_in = q_job.rsp;
                     end
                  endcase
               end
            end
            S_WAIT: begin
               rsp_valid_in = 1'b1;
               rsp_in = job_ff.rsp;
               rsp_in.data_byte = ram_rdata;
               if (job_ff.kind == JOB_READ_CLEAR) begin
                  ram_we = 1'b1;
                  ram_waddr = addr_ff;
               end
               state_in = S_IDLE;
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end

      if (clear_start) begin
         clr_in = 1'b1;
         clr_addr_in = '0;
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      addr_ff <= addr_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         clr_ff <= 1'b1;
         clr_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         clr_addr_ff <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_wait_answers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |=> rsp_valid_ff)
      else $error("read without answer");

   a_no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !q_pop)
      else $error("queue popped during store clear");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty queue");

   a_read_then_wait: assert property (@(posedge clock) disable iff (reset)
      (ram_re && !clear_start) |=> (state_ff == S_WAIT))
      else $error("store read not followed by wait");

endmodule

>>> rtl/core/dual_stack_shared_array_unit.sv
`timescale 1ns / 1ps
// Push, error, unused-code and out-of-range peek replies pass through the queue and the
// result register; pop and in-range peek also pass S_WAIT for the registered store read.
// Throughput: one push per cycle while busy is low; pop and in-range peek hold the store
// port through the read and S_WAIT, a 2-entry queue between classifier and store
// sequencer absorbs the difference. Reset and every mode write clear the store with a fill
// pass over all STORE_DEPTH slots, during which busy stays high; results are never back-pressured.
module dual_stack_shared_array_unit
   import dssa_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_strobe,
   output rsp_type rsp_word,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_word
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int QW = AW + $bits(job_type);

   logic          accept, csr_write;
   logic          enq, q_pop, q_empty, q_full, clearing;
   job_type       f_job, q_job;
   logic [AW-1:0] f_addr, q_addr;
   logic [QW-1:0] q_out;

   // take a mode word only with the queue drained; hold new commands off meanwhile
   assign csr_ready = q_empty;
   assign csr_write = csr_valid && csr_ready;
   assign busy = clearing || q_full || csr_write;
   assign accept = start && !busy;
   assign q_addr = q_out[QW-1 -: AW];
   assign q_job = q_out[$bits(job_type)-1:0];

   dssa_front #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_word   (req_word),
      .mode_write (csr_write),
      .mode_word  (csr_word),
      .enq        (enq),
      .job        (f_job),
      .job_addr   (f_addr)
   );

   dssa_fifo #(
      .WIDTH (QW)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (enq),
      .push_data ({f_addr, f_job}),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty),
      .full      (q_full)
   );

   dssa_back #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .clear_start (csr_write),
      .q_empty     (q_empty),
      .q_job       (q_job),
      .q_addr      (q_addr),
      .q_pop       (q_pop),
      .clearing    (clearing),
      .rsp_strobe  (rsp_strobe),
      .rsp_word    (rsp_word)
   );

endmodule

>>> dv/tb_dual_stack_shared_array_unit.sv
`timescale 1ns / 1ps
module tb_dual_stack_shared_array_unit;
   import dssa_pkg::*;

   localparam int DEPTH = STORE_DEPTH_DEFAULT;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int CHUNKS = 10;
   localparam int CHUNK_WORDS = 100;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_strobe;
   rsp_type rsp_word;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_word = 1'b0;

   req_type    pending_q[$];
   rsp_type    expected_q[$];
   rsp_type    want_word;
   logic [7:0] store_mirror[DEPTH];
   int         top_one;
   int         top_two;
   logic       mode_now = MODE_INTERLEAVED;
   logic       steady = 1'b0;

   int errors = 0;
   int cycles = 0;
   int accepted = 0;
   int checked = 0;
   int overflows = 0;
   int underflows = 0;
   int mode_writes = 0;

   dual_stack_shared_array_unit #(
      .STORE_DEPTH(DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_word   (csr_word)
   );

   always #4 clock = ~clock;

   function automatic void clear_stacks();
      top_one = 0;
      top_two = (mode_now == MODE_INTERLEAVED) ? 1 : DEPTH - 1;
      for (int i = 0; i < DEPTH; i++) store_mirror[i] = FILL_BYTE;
   endfunction

   function automatic rsp_type stack_apply(req_type w);
      rsp_type r;
      int      slot;
      logic    second;
      r = '0;
      second = w.stack_select;
      case (w.command)
         CMD_PUSH: begin
            slot = second ? top_two : top_one;
            if (slot < 0 || slot >= DEPTH ||
                (mode_now == MODE_COLLIDING && top_one > top_two)) begin
               r.status = ST_OVER;
            end else begin
               store_mirror[slot] = w.push_byte;
               if (mode_now == MODE_INTERLEAVED) begin
                  if (second) top_two += 2;
                  else top_one += 2;
               end else begin
                  if (second) top_two -= 1;
                  else top_one += 1;
               end
               r.status = ST_OK;
               r.slot_touched = slot[4:0];
               r.data_byte = w.push_byte;
            end
         end
         CMD_POP: begin
            if (mode_now == MODE_INTERLEAVED) slot = second ? top_two - 2 : top_one - 2;
            else slot = second ? top_two + 1 : top_one - 1;
            if (slot < 0 || slot >= DEPTH ||
                (mode_now == MODE_INTERLEAVED && second && slot < 1)) begin
               r.status = ST_UNDER;
            end else begin
               r.status = ST_OK;
               r.slot_touched = slot[4:0];
               r.data_byte = store_mirror[slot];
               store_mirror[slot] = FILL_BYTE;
               if (second) top_two = slot;
               else top_one = slot;
            end
         end
         CMD_PEEK: begin
            r.status = ST_OK;
            r.slot_touched = w.peek_slot;
            r.data_byte = (w.peek_slot < DEPTH) ? store_mirror[w.peek_slot] : FILL_BYTE;
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
   endtask

   function automatic void add_word(logic [1:0] cmd, logic sel, logic [7:0] b, logic [4:0] p);
      req_type w;
      w.command = cmd;
      w.stack_select = sel;
      w.push_byte = b;
      w.peek_slot = p;
      pending_q.push_back(w);
   endfunction

   task automatic drain();
      wait (pending_q.size() == 0);
      wait (expected_q.size() == 0);
      @(negedge clock);
   endtask

   task automatic cfg_write(logic m);
      int prior_writes;
      prior_writes = mode_writes;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_word <= m;
      wait (mode_writes != prior_writes);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // hold start low while idling, drop it when nothing is pending
   always @(negedge clock) begin
      if (reset || pending_q.size() == 0 || (!steady && $urandom_range(99) < 23)) begin
         start <= 1'b0;
      end else begin
         start <= 1'b1;
         req_word <= pending_q[0];
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_q.size() == 0) begin
               report_mismatch("result with none pending", rsp_word, 0);
            end else begin
               want_word = expected_q.pop_front();
               checked++;
               if (want_word.status == ST_OVER) overflows++;
               if (want_word.status == ST_UNDER) underflows++;
               if (rsp_word.status !== want_word.status)
                  report_mismatch("status", rsp_word.status, want_word.status);
               if (rsp_word.slot_touched !== want_word.slot_touched)
                  report_mismatch("slot_touched", rsp_word.slot_touched,
                                  want_word.slot_touched);
               if (rsp_word.data_byte !== want_word.data_byte)
                  report_mismatch("data_byte", rsp_word.data_byte, want_word.data_byte);
            end
         end
         if (start && !busy) begin
            expected_q.push_back(stack_apply(req_word));
            void'(pending_q.pop_front());
            accepted++;
         end
         if (csr_valid && csr_ready) begin
            mode_now = csr_word;
            clear_stacks();
            mode_writes++;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_dual_stack_shared_array_unit: done, errors");
         $finish;
      end
   end

   initial begin
      int   r;
      int   fill_len;
      logic sel;
      logic fill;
      logic [1:0] cmd;
      mode_now = MODE_INTERLEAVED;
      clear_stacks();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_word(CMD_PEEK, 1'b0, 8'h00, 5'd0);
      add_word(CMD_PEEK, 1'b1, 8'hFF, 5'd31);
      add_word(CMD_POP, 1'b0, 8'h00, 5'd0);
      add_word(CMD_POP, 1'b1, 8'h00, 5'd0);
      add_word(CMD_PUSH, 1'b0, 8'h00, 5'd0);
      add_word(CMD_PUSH, 1'b1, 8'hFF, 5'd31);
      add_word(CMD_PUSH, 1'b0, 8'hFF, 5'd0);
      add_word(CMD_PEEK, 1'b0, 8'h00, 5'd0);
      add_word(CMD_PEEK, 1'b0, 8'h00, 5'd1);
      add_word(CMD_POP, 1'b0, 8'h00, 5'd0);
      add_word(CMD_POP, 1'b1, 8'h00, 5'd0);
      add_word(CMD_UNUSED, 1'b1, 8'hFF, 5'd31);
      add_word(CMD_PEEK, 1'b0, 8'h00, 5'd2);
      drain();

      cfg_write(MODE_COLLIDING);
      add_word(CMD_PUSH, 1'b0, 8'hA5, 5'd0);
      add_word(CMD_PUSH, 1'b1, 8'h5A, 5'd0);
      add_word(CMD_PEEK, 1'b0, 8'h00, 5'd31);
      add_word(CMD_PEEK, 1'b1, 8'h00, 5'd0);
      add_word(CMD_POP, 1'b1, 8'h00, 5'd0);
      add_word(CMD_POP, 1'b1, 8'h00, 5'd0);
      add_word(CMD_POP, 1'b0, 8'h00, 5'd0);
      add_word(CMD_POP, 1'b0, 8'h00, 5'd0);
      add_word(CMD_PUSH, 1'b1, 8'h01, 5'd0);
      drain();

      sel = 1'b0;
      for (int c = 0; c < CHUNKS; c++) begin
         cfg_write((c < 8) ? c[0] : logic'($urandom_range(1)));
         steady = (c == 3);
         fill_len = c[0] ? 35 : 60;
         for (int k = 0; k < CHUNK_WORDS; k++) begin
            fill = (k < fill_len);
            r = $urandom_range(99);
            if (r < (fill ? 70 : 15)) cmd = CMD_PUSH;
            else if (r < 80) cmd = CMD_POP;
            else if (r < 95) cmd = CMD_PEEK;
            else cmd = CMD_UNUSED;
            if ($urandom_range(3) == 0) sel = $urandom_range(1);
            add_word(cmd, sel, 8'($urandom_range(255)), 5'($urandom_range(31)));
         end
         // pause the sender until every result of the chunk is back
         drain();
      end
      steady = 1'b0;

      repeat (8) @(posedge clock);
      if (expected_q.size() != 0)
         report_mismatch("results never returned", expected_q.size(), 0);
      $display("covered %0d commands over %0d mode writes in both placements", accepted,
               mode_writes);
      $display("checked %0d results: %0d overflows, %0d underflows", checked, overflows,
               underflows);
      if (errors == 0) begin
         $display("tb_dual_stack_shared_array_unit: done, clean");
      end else begin
         $display("tb_dual_stack_shared_array_unit: done, errors");
      end
      $finish;
   end

endmodule
